// ===== design/rtalar_pkg.sv =====
// Package for the tent-add / longest arithmetic run block.
// Holds field widths, defaults and item codes; depends on nothing.
package rtalar_pkg;
   localparam int POS_W             = 11;
   localparam int COEF_W            = 32;
   localparam int DEF_MAX_LENGTH    = 1024;
   localparam int DEF_VALUE_WIDTH   = 48;
   localparam logic [POS_W-1:0] LEN_RESET = 11'd1024;

   localparam logic ACT_ADD   = 1'b0;
   localparam logic ACT_QUERY = 1'b1;
endpackage

// ===== design/range_tent_add_longest_arith_run_top.sv =====
// Top level of the tent-add array with longest arithmetic run query.
// Depends on rtalar_pkg and rtalar_ram.
//
// The block keeps MAX_LENGTH values of VALUE_WIDTH bits, all zero after reset,
// in one value memory (one position per word). A tent add walks the memory
// from left to right, reading each word and writing it back with the tent
// increment added; a query walks the same span, tracking the longest run of
// equal adjacent differences. One memory port pair carries one position per
// cycle, and the response is posted once the scan has drained; a rejected item
// is answered in the cycle after acceptance. The next request word is accepted
// only once the response has been taken. After reset a clearing pass writes
// zero to every word, during which no word is accepted (csr writes still are).
// One response word is returned per request word; it waits in an output
// register until taken.
module range_tent_add_longest_arith_run_top #(
   parameter int MAX_LENGTH  = rtalar_pkg::DEF_MAX_LENGTH,
   parameter int VALUE_WIDTH = rtalar_pkg::DEF_VALUE_WIDTH
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_wr_en,
   input  logic [rtalar_pkg::POS_W-1:0]  csr_wr_data,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic                          req_action,
   input  logic [rtalar_pkg::POS_W-1:0]  req_left,
   input  logic [rtalar_pkg::POS_W-1:0]  req_right,
   input  logic [rtalar_pkg::POS_W-1:0]  req_peak,
   input  logic signed [rtalar_pkg::COEF_W-1:0] req_base_add,
   input  logic signed [rtalar_pkg::COEF_W-1:0] req_slope,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [rtalar_pkg::POS_W-1:0]  rsp_run_length,
   output logic                          rsp_bad_range
);
   localparam int PW = rtalar_pkg::POS_W;
   localparam int VW = VALUE_WIDTH;
   localparam int AW = $clog2(MAX_LENGTH);
   localparam logic [16:0] MAX_L = 17'(MAX_LENGTH);

   typedef enum logic [2:0] {
      ST_CLEAR = 3'b001,
      ST_IDLE  = 3'b010,
      ST_SCAN  = 3'b100
   } state_type;

   // control
   state_type         state_ff, state_in;
   logic [AW-1:0]     clr_addr_ff, clr_addr_in;
   logic [PW-1:0]     len_ff, len_in;
   logic              iss_ff, iss_in;
   logic              dv_ff, dv_in;
   logic              rsp_valid_ff, rsp_valid_in;
   // payload
   logic              act_ff, act_in;
   logic [PW-1:0]     left_ff, left_in, right_ff, right_in, peak_ff, peak_in;
   logic [VW-1:0]     slope_ff, slope_in, inc_ff, inc_in;
   logic [PW-1:0]     rd_pos_ff, rd_pos_in, dpos_ff, dpos_in;
   logic [VW-1:0]     prev_ff, prev_in, pdiff_ff, pdiff_in;
   logic [PW-1:0]     run_ff, run_in, best_ff, best_in;
   logic [PW-1:0]     rsp_len_ff, rsp_len_in;
   logic              rsp_bad_ff, rsp_bad_in;

   logic              mem_we;
   logic [AW-1:0]     mem_wa, mem_ra;
   logic [VW-1:0]     mem_wd, mem_rd;

   logic              req_acc, bad;
   logic [16:0]       len17, lim;
   logic [VW-1:0]     diff;
   logic [PW-1:0]     run_n;
   logic signed [63:0] base64, slope64;

   rtalar_ram #(.WIDTH(VW), .DEPTH(MAX_LENGTH)) u_value_ram (
      .clock  (clock),
      .wr_en  (mem_we),
      .wr_addr(mem_wa),
      .wr_data(mem_wd),
      .rd_addr(mem_ra),
      .rd_data(mem_rd)
   );

   // take a word only when idle and the output register is free
   assign req_stall = !((state_ff == ST_IDLE) && !rsp_valid_ff);
   assign req_acc   = req_valid && !req_stall;

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_run_length = rsp_len_ff;
   assign rsp_bad_range  = rsp_bad_ff;

   // bounds check against min(length in use, MAX_LENGTH)
   assign len17   = {6'b0, len_ff};
   assign lim     = (len17 > MAX_L) ? MAX_L : len17;
   assign base64  = 64'(req_base_add);
   assign slope64 = 64'(req_slope);

   always_comb begin
      bad = (req_left == '0) || (req_right < req_left) || ({6'b0, req_right} > lim);
      if (req_action == rtalar_pkg::ACT_ADD &&
          (req_peak < req_left || req_peak > req_right)) begin
         bad = 1'b1;
      end
   end

   // run tracking on the word coming back from memory
   assign diff  = mem_rd - prev_ff;
   assign run_n = (run_ff != '0 && diff == pdiff_ff) ? run_ff + 1'b1 : PW'(1);

   always_comb begin
      state_in     = state_ff;
      clr_addr_in  = clr_addr_ff;
      len_in       = csr_wr_en ? csr_wr_data : len_ff;
      iss_in       = 1'b0;
      dv_in        = 1'b0;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      act_in       = act_ff;
      left_in      = left_ff;
      right_in     = right_ff;
      peak_in      = peak_ff;
      slope_in     = slope_ff;
      inc_in       = inc_ff;
      rd_pos_in    = rd_pos_ff;
      dpos_in      = dpos_ff;
      prev_in      = prev_ff;
      pdiff_in     = pdiff_ff;
      run_in       = run_ff;
      best_in      = best_ff;
      rsp_len_in   = rsp_len_ff;
      rsp_bad_in   = rsp_bad_ff;
      mem_we       = 1'b0;
      mem_wa       = AW'(dpos_ff - 1'b1);
      mem_wd       = mem_rd + inc_ff;
      mem_ra       = AW'(rd_pos_ff - 1'b1);

      unique case (state_ff)
         ST_CLEAR: begin
            // zero one word per cycle
            mem_we      = 1'b1;
            mem_wa      = clr_addr_ff;
            mem_wd      = '0;
            clr_addr_in = clr_addr_ff + 1'b1;
            if (clr_addr_ff == AW'(MAX_LENGTH - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_acc) begin
               if (bad) begin
                  rsp_valid_in = 1'b1;
                  rsp_len_in   = '0;
                  rsp_bad_in   = 1'b1;
               end else begin
                  state_in  = ST_SCAN;
                  act_in    = req_action;
                  left_in   = req_left;
                  right_in  = req_right;
                  peak_in   = req_peak;
                  inc_in    = VW'(base64);
                  slope_in  = VW'(slope64);
                  rd_pos_in = req_left;
                  iss_in    = 1'b1;
                  run_in    = '0;
                  best_in   = '0;
               end
            end
         end
         ST_SCAN: begin
            // issue one read per cycle, left to right
            if (iss_ff) begin
               dv_in   = 1'b1;
               dpos_in = rd_pos_ff;
               if (rd_pos_ff == right_ff) begin
                  iss_in = 1'b0;
               end else begin
                  iss_in    = 1'b1;
                  rd_pos_in = rd_pos_ff + 1'b1;
               end
            end
            // handle the word read last cycle
            if (dv_ff) begin
               if (act_ff == rtalar_pkg::ACT_ADD) begin
                  mem_we = 1'b1;
                  inc_in = (dpos_ff < peak_ff) ? inc_ff + slope_ff : inc_ff - slope_ff;
               end else begin
                  prev_in = mem_rd;
                  if (dpos_ff != left_ff) begin
                     pdiff_in = diff;
                     run_in   = run_n;
                     if (run_n > best_ff) begin
                        best_in = run_n;
                     end
                  end
               end
            end
            // pipeline drained: post the response
            if (!iss_ff && !dv_ff) begin
               state_in     = ST_IDLE;
               rsp_valid_in = 1'b1;
               rsp_bad_in   = 1'b0;
               rsp_len_in   = (act_ff == rtalar_pkg::ACT_QUERY) ? best_ff + 1'b1 : '0;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_addr_ff  <= '0;
         len_ff       <= rtalar_pkg::LEN_RESET;
         iss_ff       <= 1'b0;
         dv_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_addr_ff  <= clr_addr_in;
         len_ff       <= len_in;
         iss_ff       <= iss_in;
         dv_ff        <= dv_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      act_ff     <= act_in;
      left_ff    <= left_in;
      right_ff   <= right_in;
      peak_ff    <= peak_in;
      slope_ff   <= slope_in;
      inc_ff     <= inc_in;
      rd_pos_ff  <= rd_pos_in;
      dpos_ff    <= dpos_in;
      prev_ff    <= prev_in;
      pdiff_ff   <= pdiff_in;
      run_ff     <= run_in;
      best_ff    <= best_in;
      rsp_len_ff <= rsp_len_in;
      rsp_bad_ff <= rsp_bad_in;
   end
endmodule

// ===== design/rtalar_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read.
// Depends on nothing.
module rtalar_ram #(
   parameter int WIDTH = 48,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule
